FILE: hdl/buddy_address_allocator_defines.svh
// Assertion macros for the buddy address allocator checker.
`ifndef BUDDY_ADDRESS_ALLOCATOR_DEFINES_SVH
`define BUDDY_ADDRESS_ALLOCATOR_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define BAA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("buddy allocator check failed");
// Next-cycle implication checked on every rising clock edge outside reset.
`define BAA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("buddy allocator check failed");
`endif

FILE: hdl/baa_pkg.sv
// Shared constants of the buddy address allocator.
`default_nettype none
package baa_pkg;
  // Highest block order: the window holds 2^TOP_ORDER minimum units.
  localparam int         TOP_ORDER   = 10;
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INACTIVE = 3'd1;
  localparam logic [2:0] ST_NO_SPACE = 3'd2;
  localparam logic [2:0] ST_OUTSIDE  = 3'd3;
  localparam logic [2:0] ST_MISALIGN = 3'd4;
  localparam logic       MODE_ALLOC  = 1'b0;
  localparam logic       MODE_FREE   = 1'b1;
  localparam logic       REG_NODE    = 1'b0;
  localparam logic       REG_ACTIVE  = 1'b1;
endpackage
`default_nettype wire

FILE: hdl/baa_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module baa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: hdl/buddy_address_allocator.sv
// Top level of the buddy address allocator: sequencer, list heads and link RAM.
//
// Buddy allocator over one node's window of 2^TOP_ORDER units of
// 2^MIN_BLOCK_SHIFT bytes. One request enters on s_axis (tdata: mode,
// byte_size, global_address), one result leaves on m_axis (tdata:
// result_address, status, units_in_use). The block handles one item at a
// time; s_axis_tready is low from acceptance until the result has been
// transferred. All link traffic goes through a single-port link RAM with
// registered read at one access per cycle, so the time per item is set by
// that port. Each item first passes the order search; an inactive or
// rejected item then goes to the result. An allocate scans up past empty
// orders, splits the block it finds in read, wait, low and high steps per
// split and then takes the block; an allocate with no room ends when the
// scan passes the top order. A free walks each merge level's list up to
// the buddy, unlinks it and moves up one order, until no buddy is found or
// the top order is reached, and then pushes the merged block. A walk covers
// at most 2^TOP_ORDER entries per level. Writing active=1 reloads the free
// store and writes the end-of-list link of the whole block; no other link
// entry is read before it is written.
`default_nettype none
module buddy_address_allocator #(
  parameter int MIN_BLOCK_SHIFT = 22
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // mode [0], byte_size [48:1], global_address [96:49], zero fill
  input  wire logic [103:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // result_address [47:0], status [50:48], units_in_use [61:51], zero fill
  output logic [63:0]       m_axis_tdata
);
  localparam int TOP_ORDER = baa_pkg::TOP_ORDER;
  localparam int UW   = TOP_ORDER + 1;          // unit index width incl. nil
  localparam int UNITS = 1 << TOP_ORDER;
  localparam int OW   = $clog2(TOP_ORDER + 2);
  localparam int WS   = TOP_ORDER + MIN_BLOCK_SHIFT;
  localparam logic [UW-1:0] NIL = UW'(UNITS);

  typedef enum logic [3:0] {
    S_IDLE, S_ORDER, S_DECIDE, S_SCAN, S_SPLIT_RD, S_SPLIT_WAIT, S_SPLIT_LO,
    S_SPLIT_HI, S_TAKE_RD, S_TAKE_WAIT, S_WALK_RD, S_WALK_WAIT, S_UNLINK,
    S_PUSH, S_OUT
  } state_t;

  state_t             state;
  logic [15:0]        node_number;
  logic               active;
  logic [UW-1:0]      heads [TOP_ORDER+1];
  logic [UW-1:0]      units;
  logic               mode;
  logic [47:0]        size;
  logic [47:0]        addr;
  logic [OW-1:0]      order;
  logic [OW-1:0]      cur;
  logic [47:0]        rounded;
  logic [UW-1:0]      blk;
  logic [UW-1:0]      unit;
  logic [UW-1:0]      prev;
  logic [UW-1:0]      walk;
  logic [UW:0]        steps;
  logic [47:0]        result;
  logic [2:0]         status;
  logic [63:0]        out_data;
  logic               ram_we;
  logic [TOP_ORDER-1:0] ram_addr;
  logic [UW-1:0]      ram_wdata;
  logic [UW-1:0]      ram_rdata;
  logic [UW-1:0]      buddy;
  logic [UW:0]        units_sum;
  logic [UW-1:0]      osize;

  baa_ram #(.WIDTH(UW), .DEPTH(UNITS)) u_links (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign m_axis_tdata  = out_data;
  assign buddy         = unit ^ (UW'(1) << cur);
  assign osize         = UW'(1) << order;
  assign units_sum     = {1'b0, units} + {1'b0, osize};

  // Link RAM port: one access per cycle, chosen by the sequencer state or by a reload write.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = walk[TOP_ORDER-1:0];
    ram_wdata = NIL;
    unique case (state)
      S_SPLIT_RD, S_TAKE_RD: ram_addr = heads[cur][TOP_ORDER-1:0];
      S_SPLIT_LO: begin
        ram_we    = 1'b1;
        ram_addr  = blk[TOP_ORDER-1:0];
        ram_wdata = heads[cur-OW'(1)];
      end
      S_SPLIT_HI: begin
        ram_we    = 1'b1;
        ram_addr  = buddy[TOP_ORDER-1:0] ^ blk[TOP_ORDER-1:0] ^ unit[TOP_ORDER-1:0];
        ram_wdata = blk;
      end
      S_UNLINK: begin
        // Bypass the buddy only when it sits behind another entry.
        ram_we    = (walk == buddy) && (prev != NIL);
        ram_addr  = prev[TOP_ORDER-1:0];
        ram_wdata = ram_rdata;
      end
      S_PUSH: begin
        ram_we    = 1'b1;
        ram_addr  = unit[TOP_ORDER-1:0];
        ram_wdata = heads[cur];
      end
      default: ;
    endcase
    // Reload: terminate the list that holds the whole block.
    if (cfg_we && cfg_index == baa_pkg::REG_ACTIVE && cfg_data[0]) begin
      ram_we    = 1'b1;
      ram_addr  = '0;
      ram_wdata = NIL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      node_number   <= '0;
      active        <= 1'b0;
      units         <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i <= TOP_ORDER; i++) heads[i] <= NIL;
      heads[TOP_ORDER] <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          baa_pkg::REG_NODE: node_number <= cfg_data;
          baa_pkg::REG_ACTIVE: begin
            active <= cfg_data[0];
            if (cfg_data[0]) begin
              // Reload: one whole block; its end-of-list link is written above.
              for (int i = 0; i <= TOP_ORDER; i++) heads[i] <= NIL;
              heads[TOP_ORDER] <= '0;
              units <= '0;
            end
          end
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          mode    <= s_axis_tdata[0];
          size    <= s_axis_tdata[48:1];
          addr    <= s_axis_tdata[96:49];
          order   <= '0;
          rounded <= 48'd1 << MIN_BLOCK_SHIFT;
          result  <= '0;
          status  <= baa_pkg::ST_OK;
          state   <= S_ORDER;
        end
        S_ORDER: begin
          // Advance one order per cycle until the rounded size covers the request or the top order is reached.
          if (rounded < size && order < OW'(TOP_ORDER)) begin
            rounded <= rounded << 1;
            order   <= order + OW'(1);
          end else begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          cur  <= order;
          unit <= UW'(addr[WS-1:MIN_BLOCK_SHIFT]);
          if (!active) begin
            status <= baa_pkg::ST_INACTIVE;
            state  <= S_OUT;
          end else if (mode == baa_pkg::MODE_ALLOC) begin
            state <= S_SCAN;
          end else if ((addr >> WS) != 48'(node_number)) begin
            status <= baa_pkg::ST_OUTSIDE;
            state  <= S_OUT;
          end else if ((addr[WS-1:0] & WS'((rounded - 48'd1))) != '0) begin
            status <= baa_pkg::ST_MISALIGN;
            state  <= S_OUT;
          end else begin
            state <= S_WALK_RD;
          end
        end
        S_SCAN: begin
          if (cur > OW'(TOP_ORDER)) begin
            status <= baa_pkg::ST_NO_SPACE;
            state  <= S_OUT;
          end else if (heads[cur] == NIL) begin
            cur <= cur + OW'(1);
          end else if (cur > order) begin
            state <= S_SPLIT_RD;
          end else begin
            state <= S_TAKE_RD;
          end
        end
        S_SPLIT_RD: begin
          blk   <= heads[cur] & UW'(UNITS - 1);
          state <= S_SPLIT_WAIT;
        end
        S_SPLIT_WAIT: begin
          heads[cur] <= ram_rdata;
          unit  <= blk;
          state <= S_SPLIT_LO;
        end
        S_SPLIT_LO: begin
          heads[cur-OW'(1)] <= blk;
          cur   <= cur - OW'(1);
          state <= S_SPLIT_HI;
        end
        S_SPLIT_HI: begin
          heads[cur] <= blk + (UW'(1) << cur);
          state <= (cur > order) ? S_SPLIT_RD : S_TAKE_RD;
        end
        S_TAKE_RD: begin
          blk   <= heads[cur] & UW'(UNITS - 1);
          state <= S_TAKE_WAIT;
        end
        S_TAKE_WAIT: begin
          heads[cur] <= ram_rdata;
          result <= (48'(node_number) << WS) + (48'(blk) << MIN_BLOCK_SHIFT);
          units  <= (units_sum > (UW+1)'(UNITS)) ? UW'(UNITS) : units_sum[UW-1:0];
          state  <= S_OUT;
        end
        S_WALK_RD: begin
          // Start a buddy search at the current order, or push the block once the top order is reached.
          if (cur >= OW'(TOP_ORDER)) begin
            state <= S_PUSH;
          end else begin
            prev  <= NIL;
            walk  <= heads[cur];
            steps <= '0;
            state <= S_WALK_WAIT;
          end
        end
        S_WALK_WAIT: begin
          if (walk == NIL || steps >= (UW+1)'(UNITS)) begin
            state <= S_PUSH;
          end else begin
            walk  <= walk & UW'(UNITS - 1);
            state <= S_UNLINK;
          end
        end
        S_UNLINK: begin
          // ram_rdata now holds the link of entry walk.
          if (walk == buddy) begin
            if (prev == NIL) heads[cur] <= ram_rdata;
            if (buddy < unit) unit <= buddy;
            cur   <= cur + OW'(1);
            state <= S_WALK_RD;
          end else begin
            prev  <= walk;
            walk  <= ram_rdata;
            steps <= steps + (UW+1)'(1);
            state <= S_WALK_WAIT;
          end
        end
        S_PUSH: begin
          heads[cur] <= unit & UW'(UNITS - 1);
          units <= (units >= osize) ? units - osize : '0;
          state <= S_OUT;
        end
        S_OUT: begin
          out_data      <= {(64 - 51 - UW)'(0), units, status, result};
          m_axis_tvalid <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hdl/baa_checker.sv
// Port-level checker for the buddy address allocator, bound to the top level.
`default_nettype none
`include "buddy_address_allocator_defines.svh"
module baa_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [63:0]  m_axis_tdata
);
  `BAA_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `BAA_ASSERT_IMP(a_no_accept_while_out, m_axis_tvalid, !s_axis_tready)
  `BAA_ASSERT_IMP(a_status_legal, m_axis_tvalid, m_axis_tdata[50:48] <= baa_pkg::ST_MISALIGN)
  `BAA_ASSERT_IMP(a_fail_zero_addr, m_axis_tvalid && m_axis_tdata[50:48] != baa_pkg::ST_OK,
                  m_axis_tdata[47:0] == 48'd0)
endmodule
bind buddy_address_allocator baa_checker u_baa_checker (.*);
`default_nettype wire
